FILE: hdl/fplw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fplw_pkg
// Shared types and constants for the four-level page walk block.
// ----------------------------------------------------------------------------
package fplw_pkg;

  // default depth of the table memory in 64-bit words
  localparam int TABLE_WORDS_DEF = 4096;

  // bit widths fixed by the request and result formats
  localparam int PA_W    = 52;
  localparam int LIN_W   = 48;
  localparam int WIDX_W  = 12;
  localparam int ENTRY_W = 64;
  localparam int KIND_W  = 2;

  // page size flag in a table entry
  localparam int PS_BIT = 7;

  // request types
  localparam logic REQ_WRITE     = 1'b0;
  localparam logic REQ_TRANSLATE = 1'b1;

  // page kinds
  localparam logic [KIND_W-1:0] KIND_4K = 2'd0;
  localparam logic [KIND_W-1:0] KIND_2M = 2'd1;
  localparam logic [KIND_W-1:0] KIND_1G = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BAD = 2'd3;

  typedef struct packed {
    logic               req_type;
    logic [LIN_W-1:0]   linear_addr;
    logic [WIDX_W-1:0]  word_index;
    logic [ENTRY_W-1:0] entry_value;
  } req_item_t;

  typedef struct packed {
    logic [PA_W-1:0]   phys_addr;
    logic [KIND_W-1:0] page_kind;
  } res_item_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_L4,
    ST_L3,
    ST_L2,
    ST_L1
  } walk_state_t;

endpackage

FILE: hdl/fplw_table_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fplw_table_mem
// Single-port page table memory with a synchronous (registered) read.
// ----------------------------------------------------------------------------
module fplw_table_mem #(
  parameter int DEPTH  = fplw_pkg::TABLE_WORDS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                             clk,
  input  fplw_pkg::mem_ctl_t               ctl,
  input  logic [ADDR_W-1:0]                addr,
  input  logic [fplw_pkg::ENTRY_W-1:0]     wdata,
  output logic [fplw_pkg::ENTRY_W-1:0]     rdata
);

  logic [fplw_pkg::ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wdata;
    end
    // read data holds while no read is issued
    if (ctl.rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: hdl/fplw_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fplw_walk
// Walk sequencer: table writes, four-level lookup and result formation.
// ----------------------------------------------------------------------------
module fplw_walk #(
  parameter int ADDR_W = $clog2(fplw_pkg::TABLE_WORDS_DEF)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  fplw_pkg::req_item_t           req_data,
  input  logic [fplw_pkg::PA_W-1:0]     root_base,
  input  logic [fplw_pkg::ENTRY_W-1:0]  rd_data,
  input  logic                          slot_free,
  output fplw_pkg::mem_ctl_t            mem_ctl,
  output logic [ADDR_W-1:0]             mem_addr,
  output logic [fplw_pkg::ENTRY_W-1:0]  mem_wdata,
  output logic                          res_load,
  output fplw_pkg::res_item_t           res_item
);

  fplw_pkg::walk_state_t state, state_next;
  logic [fplw_pkg::LIN_W-1:0] lin;

  logic        accept;
  logic        is_write;
  logic        ps;
  logic [39:0] frame;
  logic [8:0]  idx;

  assign accept   = req_valid && req_ready;
  assign is_write = (req_data.req_type == fplw_pkg::REQ_WRITE);
  assign ps       = rd_data[fplw_pkg::PS_BIT];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fplw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_write) begin
      lin <= req_data.linear_addr;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fplw_pkg::ST_IDLE: begin
        if (req_valid && !is_write) begin
          state_next = fplw_pkg::ST_L4;
        end
      end
      fplw_pkg::ST_L4: begin
        state_next = fplw_pkg::ST_L3;
      end
      fplw_pkg::ST_L3: begin
        if (!ps) begin
          state_next = fplw_pkg::ST_L2;
        end else if (slot_free) begin
          state_next = fplw_pkg::ST_IDLE;
        end
      end
      fplw_pkg::ST_L2: begin
        if (!ps) begin
          state_next = fplw_pkg::ST_L1;
        end else if (slot_free) begin
          state_next = fplw_pkg::ST_IDLE;
        end
      end
      fplw_pkg::ST_L1: begin
        if (slot_free) begin
          state_next = fplw_pkg::ST_IDLE;
        end
      end
      default: state_next = fplw_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_ready = 1'b0;
    mem_ctl   = '0;
    mem_wdata = req_data.entry_value;
    res_load  = 1'b0;
    res_item  = '0;
    frame     = rd_data[51:12];
    idx       = lin[38:30];
    unique case (state)
      fplw_pkg::ST_IDLE: begin
        // no request is taken while in reset
        req_ready    = !rst;
        frame        = root_base[51:12];
        idx          = req_data.linear_addr[47:39];
        mem_ctl.wr_en = req_valid && !rst && is_write;
        mem_ctl.rd_en = req_valid && !rst && !is_write;
      end
      fplw_pkg::ST_L4: begin
        mem_ctl.rd_en = 1'b1;
        idx           = lin[38:30];
      end
      fplw_pkg::ST_L3: begin
        idx                = lin[29:21];
        mem_ctl.rd_en      = !ps;
        res_load           = ps && slot_free;
        res_item.phys_addr = {rd_data[51:30], lin[29:0]};
        res_item.page_kind = fplw_pkg::KIND_1G;
      end
      fplw_pkg::ST_L2: begin
        idx                = lin[20:12];
        mem_ctl.rd_en      = !ps;
        res_load           = ps && slot_free;
        res_item.phys_addr = {rd_data[51:21], lin[20:0]};
        res_item.page_kind = fplw_pkg::KIND_2M;
      end
      fplw_pkg::ST_L1: begin
        res_load           = slot_free;
        res_item.phys_addr = {rd_data[51:12], lin[11:0]};
        res_item.page_kind = fplw_pkg::KIND_4K;
      end
      default: begin
        mem_ctl = '0;
      end
    endcase
    // table word index wraps modulo the memory depth
    if (state == fplw_pkg::ST_IDLE && is_write) begin
      mem_addr = ADDR_W'(req_data.word_index);
    end else begin
      mem_addr = ADDR_W'({frame, idx});
    end
  end

endmodule

FILE: hdl/four_level_page_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_walk
// Four-level page table walker with an internal page table memory.
// ----------------------------------------------------------------------------
// usage
//   cfg channel (cfg_valid/cfg_ready/cfg_data) loads the top-level table base;
//   cfg_ready is high outside reset, bits 11:0 of the base are ignored by the walk
//   req channel carries one request: a table write (word_index, entry_value)
//   or a translate (linear_addr)
//   res channel returns phys_addr and page_kind, one per translate request,
//   none for a write
// operation
//   a write is taken while idle and leaves the block idle; a translate does one
//   dependent table read per level through the single memory port until a leaf
//   entry (1 GiB, 2 MiB or 4 KiB page) ends the walk; the result shows on
//   res_valid in the cycle after the walk loads it; the next request is taken then
// reset
//   rst clears the walk state, the output valid flag and the table base and
//   drops both ready outputs; the table memory holds nothing defined until written
// stall
//   a finished result waits in the output register; a walk that completes
//   while it is still full holds its last read data until the slot frees
// ----------------------------------------------------------------------------
module four_level_page_walk #(
  parameter int TABLE_WORDS = fplw_pkg::TABLE_WORDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [fplw_pkg::PA_W-1:0]  cfg_data,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  fplw_pkg::req_item_t        req_data,
  output logic                       res_valid,
  input  logic                       res_ready,
  output fplw_pkg::res_item_t        res_data
);

  localparam int ADDR_W = $clog2(TABLE_WORDS);

  // table base register
  logic [fplw_pkg::PA_W-1:0] root_base;

  // memory interface between sequencer and table
  fplw_pkg::mem_ctl_t            mem_ctl;
  logic [ADDR_W-1:0]             mem_addr;
  logic [fplw_pkg::ENTRY_W-1:0]  mem_wdata;
  logic [fplw_pkg::ENTRY_W-1:0]  mem_rdata;

  // result handoff into the output register
  logic                 res_load;
  fplw_pkg::res_item_t  res_item;
  logic                 slot_free;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_base <= '0;
    end else if (cfg_valid && cfg_ready) begin
      root_base <= cfg_data;
    end
  end

  // output slot can take a result when empty or being drained this cycle
  assign slot_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // payload register needs no reset
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_data <= res_item;
    end
  end

  fplw_walk #(
    .ADDR_W (ADDR_W)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .root_base (root_base),
    .rd_data   (mem_rdata),
    .slot_free (slot_free),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .res_load  (res_load),
    .res_item  (res_item)
  );

  // reads and writes never share a cycle, so no forwarding is needed
  fplw_table_mem #(
    .DEPTH  (TABLE_WORDS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

FILE: hdl/fplw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fplw_checker
// Port-level checks for the four-level page walk block.
// ----------------------------------------------------------------------------
module fplw_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_ready,
  input fplw_pkg::req_item_t  req_data,
  input logic                 res_valid,
  input logic                 res_ready,
  input fplw_pkg::res_item_t  res_data
);

  logic xlate_acc;
  logic write_acc;

  assign xlate_acc = req_valid && req_ready
                     && (req_data.req_type == fplw_pkg::REQ_TRANSLATE);
  assign write_acc = req_valid && req_ready
                     && (req_data.req_type == fplw_pkg::REQ_WRITE);

  // stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result changed while stalled");

  // a walk keeps the block busy the next cycle
  a_walk_busy: assert property (@(posedge clk) disable iff (rst)
    xlate_acc |=> !req_ready)
    else $error("request taken during a walk");

  // a write never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    write_acc && !res_valid |=> !res_valid)
    else $error("result after a table write");

  // at least two table reads before any result
  a_walk_min: assert property (@(posedge clk) disable iff (rst)
    xlate_acc |=> !$rose(res_valid) ##1 !$rose(res_valid))
    else $error("result too early after translate");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_data.page_kind != fplw_pkg::KIND_BAD)
    else $error("illegal page kind");

endmodule

bind four_level_page_walk fplw_checker u_fplw_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req_data  (req_data),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res_data  (res_data)
);

FILE: tb/sv/four_level_page_walk_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_walk_tb
// Self-checking bench for the four-level page walker. Page tables are built
// through write requests, addresses are translated, and every result is
// compared with a walk over a mirrored copy of the table memory. No walk ever
// touches a table word that has not been written first.
// ----------------------------------------------------------------------------
module four_level_page_walk_tb;
  import fplw_pkg::*;

  localparam int TBL_WORDS = TABLE_WORDS_DEF;

  // linear address bit where each level's 9-bit index starts
  localparam int SHIFT_L4 = 39;
  localparam int SHIFT_L3 = 30;
  localparam int SHIFT_L2 = 21;
  localparam int SHIFT_L1 = 12;

  // entry content patterns for table building
  localparam int FILL_RANDOM = 0;
  localparam int FILL_ONES   = 1;
  localparam int FILL_ZERO   = 2;

  localparam logic [PA_W-1:0] PA_ONES = '1;
  localparam int DRAIN_CYCLES = 10;    // longest walk plus margin
  localparam int END_LIMIT    = 20000; // cycles allowed for the final drain
  localparam int MAX_REPORTS  = 40;

  logic            clk       = 1'b0;
  logic            rst       = 1'b1;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [PA_W-1:0] cfg_data  = '0;
  logic            req_valid = 1'b0;
  logic            req_ready;
  req_item_t       req_data  = '0;
  logic            res_valid;
  logic            res_ready = 1'b0;
  res_item_t       res_data;

  // mirrored table memory and walk configuration
  logic [ENTRY_W-1:0] pt_words [TBL_WORDS];
  bit                 pt_written [TBL_WORDS];
  logic [PA_W-1:0]    root_base = '0;

  // translations accepted and not yet returned, oldest first
  res_item_t expected_xlate [$];
  res_item_t oldest_xlate;

  int err_count     = 0;
  int req_count     = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic [LIN_W-1:0] last_lin = '0;

  always #2 clk = ~clk;

  four_level_page_walk dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  // table word hit by one level: frame bits of the base plus index times 8,
  // wrapped to the memory depth
  function automatic int table_word(input logic [PA_W-1:0] base,
                                    input logic [LIN_W-1:0] lin, input int shift);
    logic [63:0] pa;
    pa = {12'b0, base[PA_W-1:12], 12'b0} + (64'((lin >> shift) & 48'h1FF) << 3);
    return int'((pa >> 3) % TBL_WORDS);
  endfunction

  // full walk over the mirrored tables; page size flag only counts at the
  // two middle levels
  function automatic res_item_t predict_translation(input logic [LIN_W-1:0] lin);
    logic [ENTRY_W-1:0] e;
    res_item_t r;
    e = pt_words[table_word(root_base, lin, SHIFT_L4)];
    e = pt_words[table_word(e[PA_W-1:0], lin, SHIFT_L3)];
    if (e[PS_BIT]) begin
      r.phys_addr = {e[PA_W-1:30], lin[29:0]};
      r.page_kind = KIND_1G;
      return r;
    end
    e = pt_words[table_word(e[PA_W-1:0], lin, SHIFT_L2)];
    if (e[PS_BIT]) begin
      r.phys_addr = {e[PA_W-1:21], lin[20:0]};
      r.page_kind = KIND_2M;
      return r;
    end
    e = pt_words[table_word(e[PA_W-1:0], lin, SHIFT_L1)];
    r.phys_addr = {e[PA_W-1:12], lin[11:0]};
    r.page_kind = KIND_4K;
    return r;
  endfunction

  // first never-written word along the walk of lin, if any
  function automatic bit find_gap(input logic [LIN_W-1:0] lin,
                                  output int gap_word, output int gap_shift);
    logic [PA_W-1:0] base;
    logic [ENTRY_W-1:0] e;
    int w;
    base = root_base;
    for (int s = SHIFT_L4; s >= SHIFT_L1; s -= 9) begin
      w = table_word(base, lin, s);
      if (!pt_written[w]) begin
        gap_word  = w;
        gap_shift = s;
        return 1'b1;
      end
      e = pt_words[w];
      if ((s == SHIFT_L3 || s == SHIFT_L2) && e[PS_BIT]) return 1'b0;
      base = e[PA_W-1:0];
    end
    return 1'b0;
  endfunction

  // entry for one level, page size flag steered toward the wanted page kind
  function automatic logic [ENTRY_W-1:0] make_entry(input int shift,
                                                    input logic [KIND_W-1:0] kind,
                                                    input int fill);
    logic [ENTRY_W-1:0] e;
    if (fill == FILL_ONES) e = '1;
    else if (fill == FILL_ZERO) e = '0;
    else e = {$urandom, $urandom};
    if (shift == SHIFT_L3) e[PS_BIT] = (kind == KIND_1G);
    else if (shift == SHIFT_L2) e[PS_BIT] = (kind == KIND_2M);
    return e;
  endfunction

  task automatic report_mismatch(input string what);
    if (err_count < MAX_REPORTS) $display("mismatch at %0t: %s", $time, what);
    err_count++;
  endtask

  // one request on the req channel, with an optional idle gap first;
  // valid stays high afterwards so back-to-back requests need no toggle
  task automatic send_req(input req_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= item;
    do @(posedge clk); while (!req_ready);
    req_count++;
    // mirror the request in acceptance order
    if (item.req_type == REQ_WRITE) begin
      pt_words[item.word_index % TBL_WORDS]   = item.entry_value;
      pt_written[item.word_index % TBL_WORDS] = 1'b1;
    end else begin
      expected_xlate.push_back(predict_translation(item.linear_addr));
    end
  endtask

  task automatic write_entry(input int w, input logic [ENTRY_W-1:0] value);
    req_item_t item;
    item.req_type    = REQ_WRITE;
    item.linear_addr = LIN_W'({$urandom, $urandom});
    item.word_index  = WIDX_W'(w);
    item.entry_value = value;
    send_req(item);
  endtask

  task automatic translate(input logic [LIN_W-1:0] lin);
    req_item_t item;
    item.req_type    = REQ_TRANSLATE;
    item.linear_addr = lin;
    item.word_index  = WIDX_W'($urandom);
    item.entry_value = {$urandom, $urandom};
    send_req(item);
  endtask

  // build (fresh) or complete the walk of lin, then translate it; a fresh
  // build can overwrite its own upper levels when words collide, so the
  // path is always closed by filling any gap that remains
  task automatic walk_and_translate(input logic [LIN_W-1:0] lin,
                                    input logic [KIND_W-1:0] kind,
                                    input bit fresh, input int fill);
    logic [PA_W-1:0] base;
    logic [ENTRY_W-1:0] e;
    int w;
    int s;
    if (fresh) begin
      base = root_base;
      for (s = SHIFT_L4; s >= SHIFT_L1; s -= 9) begin
        w = table_word(base, lin, s);
        write_entry(w, make_entry(s, kind, fill));
        e = pt_words[w];
        if ((s == SHIFT_L3 || s == SHIFT_L2) && e[PS_BIT]) break;
        base = e[PA_W-1:0];
      end
    end
    while (find_gap(lin, w, s)) write_entry(w, make_entry(s, kind, fill));
    translate(lin);
  endtask

  // hold off new requests until every translation has come back; valid is
  // dropped before the wait starts
  task automatic wait_results_done();
    req_valid <= 1'b0;
    do @(posedge clk); while (expected_xlate.size() != 0);
  endtask

  // root base is only changed with the walker idle; writes give no result,
  // so allow a full walk time after the last one
  task automatic write_root(input logic [PA_W-1:0] value);
    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    root_base = value;
  endtask

  task automatic test_reset_and_root();
    write_root('0);
  endtask

  // page kinds, extreme addresses and entries, flag bits outside the frame,
  // colliding table words and wrap of high frame bits
  task automatic test_directed_walks();
    send_idle_pct = 12;
    recv_idle_pct = 67;
    // all-zero entries make every level land on the same word
    walk_and_translate('0, KIND_4K, 1'b1, FILL_ZERO);
    // all-ones entries: flags and high bits must be ignored, frame wraps
    walk_and_translate('1, KIND_4K, 1'b1, FILL_ONES);
    walk_and_translate(LIN_W'({$urandom, $urandom}), KIND_2M, 1'b1, FILL_RANDOM);
    walk_and_translate(LIN_W'({$urandom, $urandom}), KIND_1G, 1'b1, FILL_ONES);
    // root with every bit set, low bits ignored by the walk
    write_root(PA_ONES);
    walk_and_translate(LIN_W'({$urandom, $urandom}), KIND_1G, 1'b1, FILL_RANDOM);
    write_entry(0, '1);
    write_entry(TBL_WORDS - 1, '0);
    walk_and_translate(LIN_W'({$urandom, $urandom}), KIND_4K, 1'b0, FILL_RANDOM);
  endtask

  // mostly well-formed walks with random content, some reusing the upper
  // levels of the previous address, plus stray table writes
  task automatic test_random_traffic(input int n_items, input int s_pct, input int r_pct,
                                     input logic [PA_W-1:0] root);
    int stop_at;
    int mid_at;
    int pick;
    bit paused;
    logic [LIN_W-1:0] lin;
    logic [KIND_W-1:0] kind;
    write_root(root);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    stop_at = req_count + n_items;
    mid_at  = req_count + n_items / 2;
    paused  = 1'b0;
    while (req_count < stop_at) begin
      if (!paused && req_count >= mid_at) begin
        // sender stops until the result queue is empty
        wait_results_done();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 20) begin
        write_entry($urandom_range(TBL_WORDS - 1), {$urandom, $urandom});
      end else begin
        lin = LIN_W'({$urandom, $urandom});
        if (pick < 45) lin = {last_lin[LIN_W-1:21], lin[20:0]};
        case ($urandom_range(3))
          0, 1: kind = KIND_4K;
          2: kind = KIND_2M;
          default: kind = KIND_1G;
        endcase
        walk_and_translate(lin, kind, ($urandom_range(3) == 0), FILL_RANDOM);
        last_lin = lin;
      end
    end
  endtask

  // receiver stalls at the current rate
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker: every returned translation against the oldest prediction
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (expected_xlate.size() == 0) begin
        report_mismatch($sformatf("result with none pending: pa=%h kind=%0d",
                                  res_data.phys_addr, res_data.page_kind));
      end else begin
        oldest_xlate = expected_xlate.pop_front();
        if (res_data.phys_addr !== oldest_xlate.phys_addr)
          report_mismatch($sformatf("phys_addr %h, want %h",
                                    res_data.phys_addr, oldest_xlate.phys_addr));
        if (res_data.page_kind !== oldest_xlate.page_kind)
          report_mismatch($sformatf("page_kind %0d, want %0d",
                                    res_data.page_kind, oldest_xlate.page_kind));
      end
    end
  end

  initial begin
    int waited;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reset_and_root();
    test_directed_walks();
    // sender idles lightly, receiver heavily; then the reverse; then none
    test_random_traffic(500, 12, 67, PA_W'({$urandom, $urandom}));
    test_random_traffic(500, 67, 12, PA_ONES);
    test_random_traffic(500, 0, 0, '0);
    req_valid <= 1'b0;
    waited = 0;
    while (expected_xlate.size() != 0 && waited < END_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_xlate.size() != 0)
      report_mismatch($sformatf("%0d translations never returned", expected_xlate.size()));
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/fplw_pkg.sv
hdl/fplw_table_mem.sv
hdl/fplw_walk.sv
hdl/four_level_page_walk.sv
hdl/fplw_checker.sv
tb/sv/four_level_page_walk_tb.sv
